>>> sv/sxf_pkg.sv
// ----------------------------------------------------------------------------
// sxf_pkg
// Types and constants shared by the STX/ETX frame checker with XOR check byte.
// ----------------------------------------------------------------------------
`default_nettype none

package sxf_pkg;

  localparam int unsigned MAX_BURST_DEF  = 260;
  localparam int unsigned FRAME_OVERHEAD = 4;

  localparam logic [7:0] START_MARKER_RST = 8'h02;
  localparam logic [7:0] END_MARKER_RST   = 8'h03;

  // Register addresses (byte addresses on the configuration port).
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_START_MARKER = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_END_MARKER   = 3'd4;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_START  = 3'd1,
    STATUS_LEN_ERR    = 3'd2,
    STATUS_BAD_END    = 3'd3,
    STATUS_BAD_CHKSUM = 3'd4
  } frame_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_end;
  } item_t;

  typedef struct packed {
    result_kind_t  result_kind;
    logic [7:0]    payload_byte;
    frame_status_t frame_status;
    logic [7:0]    payload_length;
  } result_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/sxf_core.sv
// ----------------------------------------------------------------------------
// sxf_core
// Frame state and per-byte evaluation: position count, start check, length
// capture, running XOR and end-of-burst status.
// ----------------------------------------------------------------------------
`default_nettype none

module sxf_core #(
  parameter int unsigned MAX_BURST = sxf_pkg::MAX_BURST_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sxf_pkg::cfg_t   cfg,
  input  wire sxf_pkg::item_t  item,
  input  wire logic            advance,
  output logic                 res_valid,
  output sxf_pkg::result_t     res
);

  localparam int unsigned POS_W = $clog2(MAX_BURST + 1);
  // Compare width wide enough for the position and for length plus overhead.
  localparam int unsigned CMP_W = (POS_W > 9) ? POS_W + 1 : 10;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             start_ok, start_ok_next;
  logic [7:0]       length_value, length_value_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       previous_byte, previous_byte_next;

  logic [CMP_W-1:0] pos_ext;
  logic             pos_zero;
  logic             pos_one;
  logic             pos_sat;
  logic             sok;
  logic [7:0]       len;

  assign pos_ext  = CMP_W'(byte_position);
  assign pos_zero = (byte_position == '0);
  assign pos_one  = (pos_ext == CMP_W'(1));
  assign pos_sat  = (pos_ext >= CMP_W'(MAX_BURST));
  assign sok      = pos_zero ? (item.rx_byte == cfg.start_marker) : start_ok;
  assign len      = pos_zero ? 8'd0 : (pos_one ? item.rx_byte : length_value);

  always_comb begin
    byte_position_next = byte_position;
    start_ok_next      = start_ok;
    length_value_next  = length_value;
    running_xor_next   = running_xor;
    previous_byte_next = previous_byte;
    res_valid          = 1'b0;
    res                = '0;

    if (item.burst_end) begin
      res_valid          = 1'b1;
      res.result_kind    = sxf_pkg::KIND_STATUS;
      res.payload_length = len;
      priority if (!sok) begin
        res.frame_status = sxf_pkg::STATUS_BAD_START;
      end else if (pos_sat ||
                   (pos_ext + CMP_W'(1)) !=
                   (CMP_W'(len) + CMP_W'(sxf_pkg::FRAME_OVERHEAD))) begin
        res.frame_status = sxf_pkg::STATUS_LEN_ERR;
      end else if (previous_byte != cfg.end_marker) begin
        res.frame_status = sxf_pkg::STATUS_BAD_END;
      end else if (running_xor != item.rx_byte) begin
        res.frame_status = sxf_pkg::STATUS_BAD_CHKSUM;
      end else begin
        res.frame_status = sxf_pkg::STATUS_OK;
      end
      byte_position_next = '0;
      running_xor_next   = '0;
    end else if (!pos_sat) begin
      if (pos_zero) begin
        start_ok_next = (item.rx_byte == cfg.start_marker);
      end else begin
        if (pos_one) begin
          length_value_next = item.rx_byte;
        end
        running_xor_next = running_xor ^ item.rx_byte;
        // Payload spans positions 2 through length + 1.
        if (pos_ext >= CMP_W'(2) && pos_ext < (CMP_W'(length_value) + CMP_W'(2))) begin
          res_valid        = 1'b1;
          res.result_kind  = sxf_pkg::KIND_PAYLOAD;
          res.payload_byte = item.rx_byte;
        end
      end
      previous_byte_next = item.rx_byte;
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      start_ok      <= 1'b0;
      length_value  <= '0;
      running_xor   <= '0;
      previous_byte <= '0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      start_ok      <= start_ok_next;
      length_value  <= length_value_next;
      running_xor   <= running_xor_next;
      previous_byte <= previous_byte_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/stx_etx_xor_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// stx_etx_xor_frame_checker_unit
// Checks a burst framed by start and end markers with an XOR check byte.
// Path: a byte transferred in waits in the input register; its result then
// leaves through the result register. Throughput: one byte per cycle, set by
// the single evaluation stage, while result_stall does not hold the output.
// Reset: all frame state clears; start marker returns to 0x02, end marker 0x03.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_xor_frame_checker_unit #(
  parameter int unsigned MAX_BURST = sxf_pkg::MAX_BURST_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sxf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  // Byte input channel
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire sxf_pkg::item_t               item,
  // Result channel
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output sxf_pkg::result_t                  result
);

  sxf_pkg::cfg_t    cfg;
  logic             in_reg_valid;
  sxf_pkg::item_t   in_reg;
  logic             core_valid;
  sxf_pkg::result_t core_res;
  logic             out_free;
  logic             advance;
  logic             cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= sxf_pkg::START_MARKER_RST;
      cfg.end_marker   <= sxf_pkg::END_MARKER_RST;
    end else if (cfg_write) begin
      if (paddr[2] == sxf_pkg::ADDR_START_MARKER[2]) begin
        cfg.start_marker <= pwdata[7:0];
      end else begin
        cfg.end_marker <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == sxf_pkg::ADDR_START_MARKER[2]) begin
      prdata = {24'd0, cfg.start_marker};
    end else begin
      prdata = {24'd0, cfg.end_marker};
    end
  end

  // The registered byte moves on when the output register has room for any
  // result it makes; bytes that make no result always move on.
  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_reg_valid && (!core_valid || out_free);
  assign item_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_reg <= item;
    end
  end

  sxf_core #(
    .MAX_BURST(MAX_BURST)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (in_reg),
    .advance  (advance),
    .res_valid(core_valid),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && core_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_valid) begin
      result <= core_res;
    end
  end

endmodule

`default_nettype wire
